[rtl/core/sbc_pkg.sv]
// Shared types and constants for the swept box collision response block.
package sbc_pkg;

	localparam int unsigned POS_W   = 24;
	localparam int unsigned SIZE_W  = 22;
	localparam int unsigned FT_W    = 16;
	localparam int unsigned DIST_W  = 26;
	localparam int unsigned STEP_W  = 40;
	localparam int unsigned DMAG_W  = 39;
	localparam int unsigned NUM_W   = 25;
	localparam int unsigned TIME_W  = 18;
	localparam int unsigned DIV_STEPS = 16;
	localparam int unsigned QDEPTH  = 2;

	// How a slab time is produced: by division, or clamped below zero / at one.
	typedef enum logic [1:0] {
		TK_DIV,
		TK_NEG,
		TK_SAT
	} sbc_kind_t;

	typedef struct packed {
		sbc_kind_t          kind;
		logic [NUM_W-1:0]   num;
	} sbc_tdiv_t;

	typedef struct packed {
		logic                      vel_zero;
		logic                      miss_x;
		logic                      miss_y;
		logic                      dneg_x;
		logic                      dneg_y;
		logic signed [POS_W-1:0]   vx;
		logic signed [POS_W-1:0]   vy;
	} sbc_side_t;

	typedef struct packed {
		sbc_side_t           side;
		logic [DMAG_W-1:0]   dmag_x;
		logic [DMAG_W-1:0]   dmag_y;
		sbc_tdiv_t           en_x;
		sbc_tdiv_t           ex_x;
		sbc_tdiv_t           en_y;
		sbc_tdiv_t           ex_y;
	} sbc_job_t;

endpackage

[rtl/core/sbc_front.sv]
// Front end: accept a box pair, form slab distances and steps, classify slab times.
module sbc_front import sbc_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic signed [POS_W-1:0]  mover_left,
	input  logic signed [POS_W-1:0]  mover_top,
	input  logic [SIZE_W-1:0]        mover_width,
	input  logic [SIZE_W-1:0]        mover_height,
	input  logic signed [POS_W-1:0]  vel_x,
	input  logic signed [POS_W-1:0]  vel_y,
	input  logic signed [POS_W-1:0]  still_left,
	input  logic signed [POS_W-1:0]  still_top,
	input  logic [SIZE_W-1:0]        still_width,
	input  logic [SIZE_W-1:0]        still_height,
	input  logic [FT_W-1:0]          frame_time,
	input  logic                     q_ready,
	output logic                     push,
	output sbc_job_t                 push_job
);

	logic                      valid_s1, valid_s2;
	logic signed [DIST_W-1:0]  dn_x_s1, dx_x_s1, dn_y_s1, dx_y_s1;
	logic signed [STEP_W-1:0]  d_x_s1, d_y_s1;
	logic signed [POS_W-1:0]   vx_s1, vy_s1;
	sbc_job_t                  job_s2, job_c;
	logic                      s1_ready, s2_ready;
	logic signed [STEP_W:0]    prod_x, prod_y;

	function automatic sbc_tdiv_t classify(logic signed [DIST_W-1:0] num,
	                                       logic [DMAG_W-1:0] dmag);
		sbc_tdiv_t r;
		logic [NUM_W+FT_W-1:0] nsh;
		nsh = {num[NUM_W-1:0], {FT_W{1'b0}}};
		r.num = num[NUM_W-1:0];
		if (num[DIST_W-1]) begin
			r.kind = TK_NEG;
		end else if (nsh >= {2'b00, dmag}) begin
			r.kind = TK_SAT;
		end else begin
			r.kind = TK_DIV;
		end
		return r;
	endfunction

	// One slab axis: pick numerators by step sign, flag unbounded or missed slabs.
	function automatic void slab_axis(logic signed [DIST_W-1:0] dn,
	                                  logic signed [DIST_W-1:0] dx,
	                                  logic signed [STEP_W-1:0] d,
	                                  output logic miss, output logic dneg,
	                                  output logic [DMAG_W-1:0] dmag,
	                                  output sbc_tdiv_t en, output sbc_tdiv_t ex);
		logic [DMAG_W-1:0] m;
		m = d[STEP_W-1] ? DMAG_W'(-d) : d[DMAG_W-1:0];
		dneg = d[STEP_W-1];
		dmag = m;
		miss = 1'b0;
		if (d == '0) begin
			miss = !(dn[DIST_W-1] && !dx[DIST_W-1] && dx != '0);
			en.kind = TK_NEG;
			en.num = '0;
			ex.kind = TK_SAT;
			ex.num = '0;
		end else if (d[STEP_W-1]) begin
			en = classify(-dx, m);
			ex = classify(-dn, m);
		end else begin
			en = classify(dn, m);
			ex = classify(dx, m);
		end
	endfunction

	assign s2_ready = !valid_s2 || q_ready;
	assign s1_ready = !valid_s1 || s2_ready;
	assign busy     = !s1_ready;
	assign push     = valid_s2 && q_ready;
	assign push_job = job_s2;

	assign prod_x = (STEP_W+1)'(vel_x) * $signed({1'b0, frame_time});
	assign prod_y = (STEP_W+1)'(vel_y) * $signed({1'b0, frame_time});

	always_comb begin
		job_c.side.vel_zero = (vx_s1 == '0) && (vy_s1 == '0);
		job_c.side.vx = vx_s1;
		job_c.side.vy = vy_s1;
		slab_axis(dn_x_s1, dx_x_s1, d_x_s1, job_c.side.miss_x, job_c.side.dneg_x,
		          job_c.dmag_x, job_c.en_x, job_c.ex_x);
		slab_axis(dn_y_s1, dx_y_s1, d_y_s1, job_c.side.miss_y, job_c.side.dneg_y,
		          job_c.dmag_y, job_c.en_y, job_c.ex_y);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s1_ready) valid_s1 <= start;
			if (s2_ready) valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_ready && start) begin
			dn_x_s1 <= DIST_W'(still_left) - DIST_W'(mover_left) - DIST_W'(mover_width);
			dx_x_s1 <= DIST_W'(still_left) + DIST_W'(still_width) - DIST_W'(mover_left);
			dn_y_s1 <= DIST_W'(still_top) - DIST_W'(mover_top) - DIST_W'(mover_height);
			dx_y_s1 <= DIST_W'(still_top) + DIST_W'(still_height) - DIST_W'(mover_top);
			d_x_s1  <= prod_x[STEP_W-1:0];
			d_y_s1  <= prod_y[STEP_W-1:0];
			vx_s1   <= vel_x;
			vy_s1   <= vel_y;
		end
		if (s2_ready && valid_s1) job_s2 <= job_c;
	end

endmodule

[rtl/core/sbc_queue.sv]
// Two-entry request queue between front end and back end.
module sbc_queue import sbc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  sbc_job_t  push_job,
	output logic      q_ready,
	output logic      out_valid,
	output sbc_job_t  out_job
);

	sbc_job_t                    mem [QDEPTH];
	logic [$clog2(QDEPTH)-1:0]   wr_q, rd_q;
	logic [$clog2(QDEPTH):0]     cnt_q;
	logic                        pop;

	assign q_ready = cnt_q < ($clog2(QDEPTH)+1)'(QDEPTH);
	assign pop     = cnt_q != '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q      <= '0;
			rd_q      <= '0;
			cnt_q     <= '0;
			out_valid <= 1'b0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			cnt_q     <= cnt_q + ($clog2(QDEPTH)+1)'(push) - ($clog2(QDEPTH)+1)'(pop);
			out_valid <= pop;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem[wr_q] <= push_job;
		out_job <= mem[rd_q];
	end

endmodule

[rtl/core/sbc_div.sv]
// Pipelined restoring divider for one clamped slab time, one quotient bit per stage.
module sbc_div import sbc_pkg::*; (
	input  logic                      clk,
	input  sbc_tdiv_t                 in_t,
	input  logic [DMAG_W-1:0]         dmag,
	output logic signed [TIME_W-1:0]  t
);

	logic [DMAG_W-1:0]     rem_s  [DIV_STEPS+1];
	logic [DMAG_W-1:0]     dmag_s [DIV_STEPS+1];
	logic [DIV_STEPS-1:0]  quo_s  [DIV_STEPS+1];
	sbc_kind_t             kind_s [DIV_STEPS+1];

	assign rem_s[0]  = DMAG_W'({in_t.num, {FT_W{1'b0}}});
	assign dmag_s[0] = dmag;
	assign quo_s[0]  = '0;
	assign kind_s[0] = in_t.kind;

	for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_step
		logic [DMAG_W:0] r2;
		logic            ge;
		assign r2 = {rem_s[k-1], 1'b0};
		assign ge = r2 >= {1'b0, dmag_s[k-1]};
		always_ff @(posedge clk) begin
			rem_s[k]  <= ge ? DMAG_W'(r2 - {1'b0, dmag_s[k-1]}) : r2[DMAG_W-1:0];
			quo_s[k]  <= {quo_s[k-1][DIV_STEPS-2:0], ge};
			dmag_s[k] <= dmag_s[k-1];
			kind_s[k] <= kind_s[k-1];
		end
	end

	always_comb begin
		unique case (kind_s[DIV_STEPS])
			TK_NEG:  t = -TIME_W'(1);
			TK_SAT:  t = TIME_W'(1 << DIV_STEPS);
			default: t = TIME_W'(quo_s[DIV_STEPS]);
		endcase
	end

endmodule

[rtl/core/sbc_back.sv]
// Back end: slab time division, hit resolution and velocity correction.
module sbc_back import sbc_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	input  sbc_job_t                 in_job,
	output logic                     done,
	output logic                     hit,
	output logic [FT_W-1:0]          contact_time,
	output logic signed [1:0]        normal_x,
	output logic signed [1:0]        normal_y,
	output logic signed [POS_W-1:0]  new_vel_x,
	output logic signed [POS_W-1:0]  new_vel_y
);

	localparam int unsigned MAG_W  = POS_W;
	localparam int unsigned OMT_W  = FT_W + 1;
	localparam int unsigned PROD_W = MAG_W + OMT_W;

	logic signed [TIME_W-1:0]  enx, exx, eny, exy, th, ts;
	logic                      side_v_s [DIV_STEPS+1];
	sbc_side_t                 side_s   [DIV_STEPS+1];
	logic                      hit_c, xwin, ywin;

	logic                      valid_s1, hit_s1;
	logic [FT_W-1:0]           t_s1;
	logic [OMT_W-1:0]          omt_s1;
	logic signed [1:0]         nx_s1, ny_s1;
	logic signed [POS_W-1:0]   vx_s1, vy_s1;

	logic                      valid_s2, hit_s2;
	logic [FT_W-1:0]           t_s2;
	logic signed [1:0]         nx_s2, ny_s2;
	logic signed [POS_W-1:0]   vx_s2, vy_s2;
	logic [PROD_W-1:0]         px_s2, py_s2;

	function automatic logic [MAG_W-1:0] mag(logic signed [POS_W-1:0] v);
		return v[POS_W-1] ? MAG_W'(-v) : MAG_W'(v);
	endfunction

	// Add the signed correction and clamp to the velocity range.
	function automatic logic signed [POS_W-1:0] fix(logic signed [POS_W-1:0] v,
	                                                logic signed [1:0] n,
	                                                logic [PROD_W-1:0] p);
		logic signed [POS_W+1:0] c, r;
		c = (POS_W+2)'(p >> FT_W);
		if (n == 2'sd1) r = (POS_W+2)'(v) + c;
		else if (n == -2'sd1) r = (POS_W+2)'(v) - c;
		else r = (POS_W+2)'(v);
		if (r > (POS_W+2)'((1 << (POS_W-1)) - 1)) return {1'b0, {(POS_W-1){1'b1}}};
		if (r < -(POS_W+2)'(1 << (POS_W-1))) return {1'b1, {(POS_W-1){1'b0}}};
		return r[POS_W-1:0];
	endfunction

	sbc_div u_div_enx (.clk(clk), .in_t(in_job.en_x), .dmag(in_job.dmag_x), .t(enx));
	sbc_div u_div_exx (.clk(clk), .in_t(in_job.ex_x), .dmag(in_job.dmag_x), .t(exx));
	sbc_div u_div_eny (.clk(clk), .in_t(in_job.en_y), .dmag(in_job.dmag_y), .t(eny));
	sbc_div u_div_exy (.clk(clk), .in_t(in_job.ex_y), .dmag(in_job.dmag_y), .t(exy));

	// Carry the sideband alongside the divider stages.
	assign side_v_s[0] = in_valid;
	assign side_s[0]   = in_job.side;
	for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_side
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) side_v_s[k] <= 1'b0;
			else side_v_s[k] <= side_v_s[k-1];
		end
		always_ff @(posedge clk) side_s[k] <= side_s[k-1];
	end

	always_comb begin
		sbc_side_t sd;
		sd    = side_s[DIV_STEPS];
		xwin  = enx > eny;
		ywin  = enx < eny;
		th    = xwin ? enx : eny;
		ts    = (exx < exy) ? exx : exy;
		hit_c = !sd.vel_zero && !sd.miss_x && !sd.miss_y &&
		        !(enx > exy) && !(eny > exx) &&
		        !ts[TIME_W-1] && !th[TIME_W-1] && (th < TIME_W'(1 << FT_W));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			done     <= 1'b0;
		end else begin
			valid_s1 <= side_v_s[DIV_STEPS];
			valid_s2 <= valid_s1;
			done     <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		hit_s1 <= hit_c;
		t_s1   <= hit_c ? th[FT_W-1:0] : '0;
		omt_s1 <= OMT_W'(1 << FT_W) - (hit_c ? OMT_W'(th[FT_W-1:0]) : '0);
		nx_s1  <= (hit_c && xwin) ? (side_s[DIV_STEPS].dneg_x ? 2'sd1 : -2'sd1) : 2'sd0;
		ny_s1  <= (hit_c && ywin) ? (side_s[DIV_STEPS].dneg_y ? 2'sd1 : -2'sd1) : 2'sd0;
		vx_s1  <= side_s[DIV_STEPS].vx;
		vy_s1  <= side_s[DIV_STEPS].vy;

		hit_s2 <= hit_s1;
		t_s2   <= t_s1;
		nx_s2  <= nx_s1;
		ny_s2  <= ny_s1;
		vx_s2  <= vx_s1;
		vy_s2  <= vy_s1;
		px_s2  <= PROD_W'(mag(vx_s1)) * PROD_W'(omt_s1);
		py_s2  <= PROD_W'(mag(vy_s1)) * PROD_W'(omt_s1);

		hit          <= hit_s2;
		contact_time <= t_s2;
		normal_x     <= nx_s2;
		normal_y     <= ny_s2;
		new_vel_x    <= fix(vx_s2, nx_s2, px_s2);
		new_vel_y    <= fix(vy_s2, ny_s2, py_s2);
	end

endmodule

[rtl/core/swept_box_collision_response.sv]
// Top level of the swept box collision response block.
//
// Usage: drive one box pair (mover corner, size, velocity, still box corner and
// size, frame time) and raise start; the request is taken at a rising edge where
// start is high and busy is low. Requests may follow one another every cycle.
// Each request yields one result: done is high for exactly one cycle with hit,
// contact_time, normal_x, normal_y, new_vel_x and new_vel_y valid in that cycle.
// The receiver cannot hold results off; it must take them as they come.
// Path: a request passes two front stages, the two-entry queue, sixteen divider
// stages that produce one quotient bit each, and three stages for hit resolution,
// the correction multiply and saturation, before done rises.
// Throughput: one request per cycle; the divider pipelines set this figure and
// the back end never stalls, so the queue drains every cycle and busy stays low.
// Reset (arst_n low) drops every request in flight and clears all valid flags;
// no result appears for requests taken before reset.
module swept_box_collision_response import sbc_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic signed [POS_W-1:0]  mover_left,
	input  logic signed [POS_W-1:0]  mover_top,
	input  logic [SIZE_W-1:0]        mover_width,
	input  logic [SIZE_W-1:0]        mover_height,
	input  logic signed [POS_W-1:0]  vel_x,
	input  logic signed [POS_W-1:0]  vel_y,
	input  logic signed [POS_W-1:0]  still_left,
	input  logic signed [POS_W-1:0]  still_top,
	input  logic [SIZE_W-1:0]        still_width,
	input  logic [SIZE_W-1:0]        still_height,
	input  logic [FT_W-1:0]          frame_time,
	output logic                     done,
	output logic                     hit,
	output logic [FT_W-1:0]          contact_time,
	output logic signed [1:0]        normal_x,
	output logic signed [1:0]        normal_y,
	output logic signed [POS_W-1:0]  new_vel_x,
	output logic signed [POS_W-1:0]  new_vel_y
);

	logic      q_ready, push, q_valid;
	sbc_job_t  push_job, q_job;

	// Front end: form distances and steps, classify each slab time.
	sbc_front u_front (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.mover_left(mover_left), .mover_top(mover_top),
		.mover_width(mover_width), .mover_height(mover_height),
		.vel_x(vel_x), .vel_y(vel_y),
		.still_left(still_left), .still_top(still_top),
		.still_width(still_width), .still_height(still_height),
		.frame_time(frame_time),
		.q_ready(q_ready), .push(push), .push_job(push_job)
	);

	// Hold classified requests until the back end takes them.
	sbc_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .push_job(push_job),
		.q_ready(q_ready), .out_valid(q_valid), .out_job(q_job)
	);

	// Back end: divide, resolve the hit, correct the velocity.
	sbc_back u_back (
		.clk(clk), .arst_n(arst_n), .in_valid(q_valid), .in_job(q_job),
		.done(done), .hit(hit), .contact_time(contact_time),
		.normal_x(normal_x), .normal_y(normal_y),
		.new_vel_x(new_vel_x), .new_vel_y(new_vel_y)
	);

	// At most one axis carries a normal.
	a_one_normal: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (normal_x == 2'sd0 || normal_y == 2'sd0))
		else $error("both normals set");

	// A miss reports zero time and no normal.
	a_miss_clean: assert property (@(posedge clk) disable iff (!arst_n)
		done && !hit |-> contact_time == '0 && normal_x == 2'sd0 && normal_y == 2'sd0)
		else $error("miss result not clean");

	// The back end drains the queue every cycle, so the front never backs up.
	a_no_backup: assert property (@(posedge clk) disable iff (!arst_n)
		!busy)
		else $error("front end stalled");

endmodule

[test/swept_box_collision_response_tb.sv]
// Self-checking testbench for the swept box collision response block.
module swept_box_collision_response_tb;
	import sbc_pkg::*;

	// One box pair request and the response it should produce.
	typedef struct {
		logic signed [POS_W-1:0] ml, mt, vx, vy, sl, st;
		logic [SIZE_W-1:0]       mw, mh, sw, sh;
		logic [FT_W-1:0]         ft;
	} pair_t;

	typedef struct {
		logic                    hit;
		logic [FT_W-1:0]         t;
		logic signed [1:0]       nx, ny;
		logic signed [POS_W-1:0] nvx, nvy;
	} response_t;

	localparam longint T_LO = -(64'sd1 <<< 62);
	localparam longint T_HI = (64'sd1 <<< 62);

	// Floor division on signed 64-bit values.
	function automatic longint fdiv(longint n, longint d);
		longint q;
		longint r;
		q = n / d;
		r = n % d;
		if (r != 0 && ((r < 0) != (d < 0)))
			q = q - 1;
		return q;
	endfunction

	// Entry and exit times of one axis slab; returns 0 when the slab misses.
	function automatic bit slab_times(longint dn, longint dx, longint d,
			output longint en, output longint ex);
		longint a;
		longint b;
		en = 0;
		ex = 0;
		if (d == 0) begin
			if (dn < 0 && dx > 0) begin
				en = T_LO;
				ex = T_HI;
				return 1;
			end
			return 0;
		end
		a = fdiv(dn * 64'sd4294967296, d);
		b = fdiv(dx * 64'sd4294967296, d);
		if (d > 0) begin
			en = a;
			ex = b;
		end else begin
			en = b;
			ex = a;
		end
		return 1;
	endfunction

	// Velocity after pushing back by |v| * n * (1 - t), saturated.
	function automatic logic signed [POS_W-1:0] vel_after_contact(longint v, int n,
			longint t);
		longint mag;
		longint c;
		longint r;
		mag = v < 0 ? -v : v;
		c = (mag * (65536 - t)) >>> 16;
		r = v + n * c;
		if (r > 8388607)
			r = 8388607;
		if (r < -8388608)
			r = -8388608;
		return r[POS_W-1:0];
	endfunction

	function automatic response_t predict_response(pair_t p);
		response_t res;
		longint vx, vy, dxs, dys, enx, exx, eny, exy, th, ts;
		bit okx, oky;
		vx = p.vx;
		vy = p.vy;
		res.hit = 1'b0;
		res.t = '0;
		res.nx = 2'sd0;
		res.ny = 2'sd0;
		res.nvx = p.vx;
		res.nvy = p.vy;
		if (vx != 0 || vy != 0) begin
			dxs = vx * longint'(p.ft);
			dys = vy * longint'(p.ft);
			okx = slab_times(longint'(p.sl) - p.ml - longint'(p.mw),
				longint'(p.sl) + longint'(p.sw) - p.ml, dxs, enx, exx);
			oky = slab_times(longint'(p.st) - p.mt - longint'(p.mh),
				longint'(p.st) + longint'(p.sh) - p.mt, dys, eny, exy);
			if (okx && oky && !(enx > exy || eny > exx)) begin
				th = enx > eny ? enx : eny;
				ts = exx < exy ? exx : exy;
				if (ts >= 0 && th >= 0 && th < 65536) begin
					res.hit = 1'b1;
					res.t = th[15:0];
					if (enx > eny)
						res.nx = dxs < 0 ? 2'sd1 : -2'sd1;
					else if (enx < eny)
						res.ny = dys < 0 ? 2'sd1 : -2'sd1;
					res.nvx = vel_after_contact(vx, res.nx, th);
					res.nvy = vel_after_contact(vy, res.ny, th);
				end
			end
		end
		return res;
	endfunction

	// Holds predicted responses in request order and checks arrivals.
	class response_board;
		response_t pending[$];
		int errors = 0;

		function void note_request(pair_t p);
			pending.insert(pending.size(), predict_response(p));
		endfunction

		function void check_response(response_t got);
			response_t want;
			if (pending.size() == 0) begin
				$display("%0t: response with none pending", $time);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (got.hit !== want.hit) begin
				$display("%0t: hit exp %0d got %0d", $time, want.hit, got.hit);
				errors++;
			end
			if (got.t !== want.t) begin
				$display("%0t: contact_time exp %0d got %0d", $time, want.t, got.t);
				errors++;
			end
			if (got.nx !== want.nx) begin
				$display("%0t: normal_x exp %0d got %0d", $time, want.nx, got.nx);
				errors++;
			end
			if (got.ny !== want.ny) begin
				$display("%0t: normal_y exp %0d got %0d", $time, want.ny, got.ny);
				errors++;
			end
			if (got.nvx !== want.nvx) begin
				$display("%0t: new_vel_x exp %0d got %0d", $time, want.nvx, got.nvx);
				errors++;
			end
			if (got.nvy !== want.nvy) begin
				$display("%0t: new_vel_y exp %0d got %0d", $time, want.nvy, got.nvy);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic busy, done, hit;
	logic signed [POS_W-1:0] mover_left = 0, mover_top = 0, vel_x = 0, vel_y = 0;
	logic signed [POS_W-1:0] still_left = 0, still_top = 0;
	logic [SIZE_W-1:0] mover_width = 0, mover_height = 0, still_width = 0, still_height = 0;
	logic [FT_W-1:0] frame_time = 0;
	logic [FT_W-1:0] contact_time;
	logic signed [1:0] normal_x, normal_y;
	logic signed [POS_W-1:0] new_vel_x, new_vel_y;

	response_board board = new();
	longint cycles = 0;
	int hits = 0;
	int requests = 0;

	swept_box_collision_response uut (.*);

	always #6 clk = ~clk;

	// Check every response at the edge that ends its strobe cycle.
	always @(posedge clk) begin
		response_t got;
		cycles <= cycles + 1;
		if (arst_n && done) begin
			got.hit = hit;
			got.t = contact_time;
			got.nx = normal_x;
			got.ny = normal_y;
			got.nvx = new_vel_x;
			got.nvy = new_vel_y;
			if (hit)
				hits++;
			board.check_response(got);
		end
	end

	// Abort on a hung pipeline.
	always @(posedge clk) begin
		if (cycles > 200000) begin
			$display("tb: failure");
			$finish;
		end
	end

	// Present one request and hold it until accepted.
	task automatic send_request(pair_t p);
		mover_left <= p.ml;
		mover_top <= p.mt;
		mover_width <= p.mw;
		mover_height <= p.mh;
		vel_x <= p.vx;
		vel_y <= p.vy;
		still_left <= p.sl;
		still_top <= p.st;
		still_width <= p.sw;
		still_height <= p.sh;
		frame_time <= p.ft;
		start <= 1;
		do
			@(posedge clk);
		while (busy);
		board.note_request(p);
		requests++;
	endtask

	task automatic idle_cycles(int n);
		start <= 0;
		repeat (n)
			@(posedge clk);
	endtask

	// Random pair; mostly small boxes near each other so hits are common.
	function automatic pair_t random_pair();
		pair_t p;
		int mode;
		mode = $urandom_range(0, 9);
		if (mode < 7) begin
			p.ml = POS_W'($signed($urandom_range(0, 8192)) - 4096);
			p.mt = POS_W'($signed($urandom_range(0, 8192)) - 4096);
			p.mw = SIZE_W'($urandom_range(0, 2048));
			p.mh = SIZE_W'($urandom_range(0, 2048));
			p.sl = POS_W'($signed($urandom_range(0, 8192)) - 4096);
			p.st = POS_W'($signed($urandom_range(0, 8192)) - 4096);
			p.sw = SIZE_W'($urandom_range(0, 2048));
			p.sh = SIZE_W'($urandom_range(0, 2048));
			p.vx = POS_W'($signed($urandom_range(0, 65536)) - 32768);
			p.vy = POS_W'($signed($urandom_range(0, 65536)) - 32768);
			if ($urandom_range(0, 7) == 0)
				p.vx = '0;
			if ($urandom_range(0, 7) == 0)
				p.vy = '0;
			p.ft = FT_W'($urandom_range(0, 3) == 0 ? $urandom
				: $urandom_range(0, 8192) + 4096);
		end else begin
			// Full-range noise reaches every bit of every field.
			p.ml = POS_W'($urandom);
			p.mt = POS_W'($urandom);
			p.mw = SIZE_W'($urandom);
			p.mh = SIZE_W'($urandom);
			p.vx = POS_W'($urandom);
			p.vy = POS_W'($urandom);
			p.sl = POS_W'($urandom);
			p.st = POS_W'($urandom);
			p.sw = SIZE_W'($urandom);
			p.sh = SIZE_W'($urandom);
			p.ft = FT_W'($urandom);
		end
		return p;
	endfunction

	function automatic pair_t make_pair(int ml, int mt, int mw, int mh, int vx, int vy,
			int sl, int st, int sw, int sh, int ft);
		pair_t p;
		p.ml = POS_W'(ml); p.mt = POS_W'(mt); p.mw = SIZE_W'(mw); p.mh = SIZE_W'(mh);
		p.vx = POS_W'(vx); p.vy = POS_W'(vy);
		p.sl = POS_W'(sl); p.st = POS_W'(st); p.sw = SIZE_W'(sw); p.sh = SIZE_W'(sh);
		p.ft = FT_W'(ft);
		return p;
	endfunction

	initial begin
		pair_t p;
		int left;
		int burst;
		repeat (11)
			@(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: hits moving right, down (a landing), up and left; zero velocity, zero frame time.
		send_request(make_pair(0, 0, 256, 256, 2560, 0, 1024, 0, 256, 256, 32768));
		send_request(make_pair(0, 0, 256, 256, 0, 2560, 0, 1024, 256, 256, 32768));
		send_request(make_pair(0, 0, 256, 256, 0, -2560, 0, -1024, 256, 256, 32768));
		send_request(make_pair(0, 0, 256, 256, -2560, 0, -1024, 0, 256, 256, 32768));
		send_request(make_pair(0, 0, 256, 256, 0, 0, 100, 0, 256, 256, 65535));
		send_request(make_pair(0, 0, 256, 256, 2560, 2560, 1024, 0, 256, 256, 0));
		// Zero step on one axis, inside and outside the slab.
		send_request(make_pair(0, 0, 256, 256, 2560, 0, 1024, -64, 256, 512, 32768));
		send_request(make_pair(0, 0, 256, 256, 2560, 0, 1024, 256, 256, 512, 32768));
		// Corner tie, separated slabs, behind the ray, out of step.
		send_request(make_pair(0, 0, 256, 256, 2560, 2560, 1024, 1024, 256, 256, 32768));
		send_request(make_pair(0, 0, 256, 256, 2560, 256, 1024, 4096, 256, 256, 32768));
		send_request(make_pair(2048, 0, 256, 256, 2560, 0, 0, 0, 256, 256, 32768));
		send_request(make_pair(0, 0, 256, 256, 256, 0, 8192, 0, 256, 256, 1000));
		// Field extremes and saturation of the corrected velocity.
		send_request(make_pair(-8388608, -8388608, 4194303, 4194303, 8388607, -8388608,
			8388607, 8388607, 4194303, 4194303, 65535));
		send_request(make_pair(8388607, 8388607, 0, 0, -8388608, 8388607,
			-8388608, -8388608, 0, 0, 65535));
		send_request(make_pair(0, 0, 0, 0, 8388607, 8388607, 256, 256, 0, 0, 1));
		send_request(make_pair(-100, -100, 4194303, 4194303, -8388608, -8388608,
			-8388608, -8388608, 4194303, 4194303, 65535));

		// Wait for every response before the random bursts.
		start <= 0;
		while (board.pending.size() != 0)
			@(posedge clk);

		left = 1040;
		while (left > 0) begin
			burst = $urandom_range(1, 40);
			while (burst > 0 && left > 0) begin
				p = random_pair();
				send_request(p);
				burst--;
				left--;
			end
			if ($urandom_range(0, 2) != 0)
				idle_cycles($urandom_range(1, 30));
		end
		start <= 0;

		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (30)
			@(posedge clk);

		$display("Sent %0d box pairs with directed edge cases and random bursts;", requests);
		$display("%0d responses reported a hit.", hits);
		if (board.errors == 0 && board.pending.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule

[files.f]
rtl/core/sbc_pkg.sv
rtl/core/sbc_front.sv
rtl/core/sbc_queue.sv
rtl/core/sbc_div.sv
rtl/core/sbc_back.sv
rtl/core/swept_box_collision_response.sv
test/swept_box_collision_response_tb.sv
